/* sv/sdtf_pkg.sv */
package sdtf_pkg;

	// field widths of the request and result channels
	localparam int unsigned NUM_W    = 32;
	localparam int unsigned FWIDTH_W = 5;
	localparam int unsigned CHAR_W   = 7;

	// default limit on the padded field width
	localparam int unsigned MAX_FIELD_WIDTH_DEF = 16;

	// decimal conversion: ten digits cover any 32-bit magnitude
	localparam int unsigned DIGITS   = 10;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned BCD_W    = DIGITS * DIGIT_W;
	localparam int unsigned NDIG_W   = 4;
	localparam int unsigned BITCNT_W = $clog2(NUM_W);

	// character codes
	localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_NINE  = 7'h39;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIZE,
		ST_EMIT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic conv;
		logic size;
		logic emit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic conv_done;
		logic rem_zero;
		logic out_free;
	} dp_sts_t;

endpackage

/* sv/sdtf_ctrl.sv */
module sdtf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sdtf_pkg::dp_sts_t   sts,
	output sdtf_pkg::ctrl_cmd_t cmd
);

	sdtf_pkg::state_t state_q;
	sdtf_pkg::state_t state_nxt;

	// advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sdtf_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			sdtf_pkg::ST_IDLE: begin
				if (in_valid) state_nxt = sdtf_pkg::ST_CONV;
			end
			sdtf_pkg::ST_CONV: begin
				if (sts.conv_done) state_nxt = sdtf_pkg::ST_SIZE;
			end
			sdtf_pkg::ST_SIZE: begin
				state_nxt = sdtf_pkg::ST_EMIT;
			end
			sdtf_pkg::ST_EMIT: begin
				if (sts.out_free && sts.rem_zero) state_nxt = sdtf_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = sdtf_pkg::ST_IDLE;
			end
		endcase
	end

	// commands to the datapath
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			sdtf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			sdtf_pkg::ST_CONV: begin
				cmd.conv = 1'b1;
			end
			sdtf_pkg::ST_SIZE: begin
				cmd.size = 1'b1;
			end
			sdtf_pkg::ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// sizing follows only a finished conversion
	a_size_after_conv: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sdtf_pkg::ST_SIZE |-> $past(state_q) == sdtf_pkg::ST_CONV)
		else $error("sizing step without a conversion before it");

endmodule

/* sv/sdtf_datapath.sv */
module sdtf_datapath #(
	parameter int unsigned MAX_FIELD_WIDTH = sdtf_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [sdtf_pkg::NUM_W-1:0]   number,
	input  logic [sdtf_pkg::FWIDTH_W-1:0]       field_width,
	input  sdtf_pkg::ctrl_cmd_t                 cmd,
	output sdtf_pkg::dp_sts_t                   sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [sdtf_pkg::CHAR_W-1:0]         ascii_char,
	output logic                                is_last
);

	localparam int unsigned CNT_W = $clog2(MAX_FIELD_WIDTH + 1);
	localparam int unsigned REM_W = $clog2(MAX_FIELD_WIDTH);
	localparam int unsigned CMP_W =
		(CNT_W > sdtf_pkg::FWIDTH_W) ? CNT_W : sdtf_pkg::FWIDTH_W;
	localparam logic [CMP_W-1:0] MAX_CMP = CMP_W'(MAX_FIELD_WIDTH);

	logic [sdtf_pkg::NUM_W-1:0]                        mag_q;
	logic [sdtf_pkg::DIGITS-1:0][sdtf_pkg::DIGIT_W-1:0] bcd_q;
	logic [sdtf_pkg::DIGITS-1:0][sdtf_pkg::DIGIT_W-1:0] bcd_adj;
	logic [sdtf_pkg::BITCNT_W-1:0]                     bitcnt_q;
	logic                                              neg_q;
	logic [CNT_W-1:0]                                  width_q;
	logic [CNT_W-1:0]                                  width_sat;
	logic [sdtf_pkg::NDIG_W-1:0]                       ndig_q;
	logic [sdtf_pkg::NDIG_W-1:0]                       ndig_c;
	logic [CNT_W-1:0]                                  textlen;
	logic [CNT_W-1:0]                                  total;
	logic [REM_W-1:0]                                  rem_q;
	logic [CNT_W-1:0]                                  rem_x;
	logic [CNT_W-1:0]                                  ndig_x;
	logic [sdtf_pkg::CHAR_W-1:0]                       char_c;
	logic                                              out_valid_q;
	logic [sdtf_pkg::CHAR_W-1:0]                       char_q;
	logic                                              last_q;

	// saturate the requested width to the limit
	assign width_sat = (CMP_W'(field_width) > MAX_CMP) ? CNT_W'(MAX_FIELD_WIDTH)
		: CNT_W'(field_width);

	// add three to every digit of five or more before the shift
	always_comb begin
		for (int d = 0; d < sdtf_pkg::DIGITS; d++) begin
			bcd_adj[d] = (bcd_q[d] >= 4'd5) ? bcd_q[d] + 4'd3 : bcd_q[d];
		end
	end

	// count significant digits, at least one
	always_comb begin
		ndig_c = 4'd1;
		for (int d = 1; d < sdtf_pkg::DIGITS; d++) begin
			if (bcd_q[d] != '0) ndig_c = sdtf_pkg::NDIG_W'(d + 1);
		end
	end

	assign textlen = CNT_W'(ndig_c) + CNT_W'(1);
	assign total   = (width_q > textlen) ? width_q : textlen;

	// conversion and sizing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitcnt_q <= '0;
		end else if (cmd.load) begin
			bitcnt_q <= '0;
		end else if (cmd.conv) begin
			bitcnt_q <= bitcnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q   <= number[sdtf_pkg::NUM_W-1];
			mag_q   <= number[sdtf_pkg::NUM_W-1] ? ('0 - $unsigned(number))
				: $unsigned(number);
			bcd_q   <= '0;
			width_q <= width_sat;
		end else if (cmd.conv) begin
			{bcd_q, mag_q} <= {bcd_adj, mag_q} << 1;
		end
		if (cmd.size) begin
			ndig_q <= ndig_c;
			rem_q  <= REM_W'(total - CNT_W'(1));
		end else if (cmd.emit) begin
			rem_q  <= rem_q - 1'b1;
		end
	end

	// pick the character at the current position, counted from the end
	assign rem_x  = CNT_W'(rem_q);
	assign ndig_x = CNT_W'(ndig_q);

	always_comb begin
		if (rem_x > ndig_x) begin
			char_c = sdtf_pkg::CH_SPACE;
		end else if (rem_x == ndig_x) begin
			char_c = neg_q ? sdtf_pkg::CH_MINUS : sdtf_pkg::CH_SPACE;
		end else begin
			char_c = sdtf_pkg::CH_ZERO
				| sdtf_pkg::CHAR_W'(bcd_q[rem_q[sdtf_pkg::NDIG_W-1:0]]);
		end
	end

	// output register: load a character, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			char_q <= char_c;
			last_q <= (rem_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign is_last    = last_q;

	assign sts.conv_done = (bitcnt_q == sdtf_pkg::BITCNT_W'(sdtf_pkg::NUM_W - 1));
	assign sts.rem_zero  = (rem_q == '0);
	assign sts.out_free  = !out_valid_q || out_ready;

	// the final character of a number is always a digit
	a_last_is_digit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && rem_q == '0 |=> is_last && ascii_char >= sdtf_pkg::CH_ZERO
		&& ascii_char <= sdtf_pkg::CH_NINE)
		else $error("last character is not a digit");

	a_not_last_early: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && rem_q != '0 |=> !is_last)
		else $error("last mark before the end of the text");

	a_sign_place: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && rem_x == ndig_x |=> ascii_char == sdtf_pkg::CH_MINUS
		|| ascii_char == sdtf_pkg::CH_SPACE)
		else $error("sign position carries a digit");

endmodule

/* sv/signed_decimal_text_formatter_unit.sv */
// Prints a signed 32-bit number as right-justified decimal ASCII, one
// character per result: leading spaces up to field_width (saturated to
// MAX_FIELD_WIDTH), a sign character ('-' or space, always present), then
// the digits most significant first, with is_last on the final digit. One
// number is handled at a time: after the request is taken, a bit-serial
// binary-to-decimal conversion (shift and add-three, one bit a cycle) and
// a sizing step follow, then characters leave one per cycle while the sink
// keeps up. A new request is taken as soon as the last character sits in
// the output register.
module signed_decimal_text_formatter_unit #(
	parameter int unsigned MAX_FIELD_WIDTH = sdtf_pkg::MAX_FIELD_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [sdtf_pkg::NUM_W-1:0]  number,
	input  logic [sdtf_pkg::FWIDTH_W-1:0]      field_width,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [sdtf_pkg::CHAR_W-1:0]        ascii_char,
	output logic                               is_last
);

	sdtf_pkg::ctrl_cmd_t cmd;
	sdtf_pkg::dp_sts_t   sts;

	sdtf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sdtf_datapath #(
		.MAX_FIELD_WIDTH (MAX_FIELD_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.number      (number),
		.field_width (field_width),
		.cmd         (cmd),
		.sts         (sts),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ascii_char  (ascii_char),
		.is_last     (is_last)
	);

endmodule
